### rtl/core/mhpq_pkg.sv
package mhpq_pkg;

  // Fixed field widths of the request and result channels
  localparam int KEY_W    = 32;
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 6;
  localparam int TOTAL_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHANGE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // take a new request
    logic take_last;    // load the last entry as the moving key for a delete
    logic place;        // write the moving key at the hole
    logic read_parent;  // fetch the parent of the hole
    logic move_up;      // drop the parent into the hole, hole climbs
    logic read_kids;    // fetch both children of the hole
    logic move_down;    // lift the larger child into the hole, hole descends
  } mhpq_cmd_t;

  // Flags from the datapath to the controller
  typedef struct packed {
    logic go_ins;   // insert accepted
    logic go_del;   // delete accepted with entries left to sift
    logic go_chg;   // change accepted, old key being fetched
    logic chg_lt;   // new key below old key
    logic chg_gt;   // new key above old key
    logic at_root;  // hole at the root
    logic is_leaf;  // hole has no children
    logic up_move;  // parent smaller than the moving key
    logic dn_move;  // moving key smaller than the chosen child
  } mhpq_stat_t;

endpackage

### rtl/core/mhpq_ram.sv
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    ra_data <= mem_r[ra_addr];
    rb_data <= mem_r[rb_addr];
  end

endmodule

### rtl/core/mhpq_dp.sv
module mhpq_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mhpq_pkg::mhpq_cmd_t                  cmd,
  output mhpq_pkg::mhpq_stat_t                 stat,
  input  logic [mhpq_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [mhpq_pkg::KEY_W-1:0]    in_key_value,
  input  logic [mhpq_pkg::IDX_W-1:0]           in_heap_index,
  output logic signed [mhpq_pkg::KEY_W-1:0]    out_removed_value,
  output logic signed [mhpq_pkg::KEY_W-1:0]    out_top_value,
  output logic [mhpq_pkg::TOTAL_W-1:0]         out_entry_total,
  output logic [mhpq_pkg::STATUS_W-1:0]        out_status
);
  import mhpq_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Compare width: holds 2*pos+2, the count and the request index
  localparam int EW     = (ADDR_W + 2 > IDX_W + 1) ? ADDR_W + 2 : IDX_W + 1;

  logic signed [KEY_W-1:0]    k_r, k_nxt;
  logic [ADDR_W-1:0]          pos_r, pos_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic signed [KEY_W-1:0]    top_r;
  logic signed [KEY_W-1:0]    removed_r, removed_nxt;
  logic [STATUS_W-1:0]        status_r, status_nxt;

  logic [EW-1:0]              cnt_e, idx_e, left_e, right_e;
  logic [CNT_W-1:0]           cnt_m1;
  logic [ADDR_W-1:0]          parent;
  logic                       is_full, is_empty, idx_bad;
  logic [STATUS_W-1:0]        req_status;
  logic signed [KEY_W-1:0]    rd_a, rd_b, pick_val;
  logic [ADDR_W-1:0]          ra_addr, rb_addr, pick_pos;
  logic                       right_ok, pick_right;
  logic                       we;
  logic signed [KEY_W-1:0]    wdata;

  // Index arithmetic
  assign cnt_e   = EW'(count_r);
  assign idx_e   = EW'(in_heap_index);
  assign cnt_m1  = count_r - CNT_W'(1);
  assign left_e  = EW'({pos_r, 1'b1});
  assign right_e = left_e + EW'(1);
  assign parent  = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);

  // Check the incoming request
  assign is_full  = (cnt_e == EW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign idx_bad  = (idx_e >= cnt_e);

  always_comb begin
    unique case (in_req_type)
      REQ_INSERT: req_status = is_full  ? ST_FULL  : ST_OK;
      REQ_DELETE: req_status = is_empty ? ST_EMPTY : ST_OK;
      REQ_CHANGE: req_status = idx_bad  ? ST_RANGE : ST_OK;
      default:    req_status = ST_OK;
    endcase
  end

  // Choose the larger child; right only if strictly larger and present
  assign right_ok   = (right_e < cnt_e);
  assign pick_right = right_ok && (rd_b > rd_a);
  assign pick_val   = pick_right ? rd_b : rd_a;
  assign pick_pos   = pick_right ? right_e[ADDR_W-1:0] : left_e[ADDR_W-1:0];

  // Flags for the controller
  always_comb begin
    stat         = '0;
    stat.go_ins  = (in_req_type == REQ_INSERT) && !is_full;
    stat.go_del  = (in_req_type == REQ_DELETE) && !is_empty && (count_r != CNT_W'(1));
    stat.go_chg  = (in_req_type == REQ_CHANGE) && !idx_bad;
    stat.chg_lt  = (k_r < rd_a);
    stat.chg_gt  = (k_r > rd_a);
    stat.at_root = (pos_r == '0);
    stat.is_leaf = (left_e >= cnt_e);
    stat.up_move = (rd_a < k_r);
    stat.dn_move = (k_r < pick_val);
  end

  // Read addresses
  always_comb begin
    priority if (cmd.capture) begin
      ra_addr = (in_req_type == REQ_DELETE) ? cnt_m1[ADDR_W-1:0] : idx_e[ADDR_W-1:0];
    end else if (cmd.read_parent) begin
      ra_addr = parent;
    end else begin
      ra_addr = left_e[ADDR_W-1:0];
    end
  end
  assign rb_addr = right_e[ADDR_W-1:0];

  // Write port: hole fill
  assign we    = cmd.place || cmd.move_up || cmd.move_down;
  always_comb begin
    priority if (cmd.move_up) begin
      wdata = rd_a;
    end else if (cmd.move_down) begin
      wdata = pick_val;
    end else begin
      wdata = k_r;
    end
  end

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (pos_r),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (rd_a),
    .rb_addr (rb_addr),
    .rb_data (rd_b)
  );

  // Next values of the working registers
  always_comb begin
    k_nxt       = k_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    if (cmd.capture) begin
      k_nxt       = in_key_value;
      removed_nxt = KEY_MIN;
      status_nxt  = req_status;
      if (stat.go_ins) begin
        pos_nxt   = count_r[ADDR_W-1:0];
        count_nxt = count_r + CNT_W'(1);
      end
      if ((in_req_type == REQ_DELETE) && !is_empty) begin
        removed_nxt = top_r;
        count_nxt   = cnt_m1;
      end
      if (stat.go_chg) begin
        pos_nxt = idx_e[ADDR_W-1:0];
      end
    end
    if (cmd.take_last) begin
      k_nxt   = rd_a;
      pos_nxt = '0;
    end
    if (cmd.move_up) begin
      pos_nxt = parent;
    end
    if (cmd.move_down) begin
      pos_nxt = pick_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload registers; shadow the root so the top needs no read
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    pos_r     <= pos_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (we && (pos_r == '0)) begin
      top_r <= wdata;
    end
  end

  assign out_removed_value = removed_r;
  assign out_top_value     = (count_r == '0) ? KEY_MIN : top_r;
  assign out_entry_total   = TOTAL_W'(count_r);
  assign out_status        = status_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_e <= EW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && stat.go_ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted insert did not grow the heap");

  a_up_write_hole: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_up |=> pos_r < $past(pos_r))
    else $error("sift up did not climb");

endmodule

### rtl/core/mhpq_ctrl.sv
module mhpq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  output mhpq_pkg::mhpq_cmd_t  cmd,
  input  mhpq_pkg::mhpq_stat_t stat
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAST   = 3'd1;
  localparam logic [2:0] S_CHG    = 3'd2;
  localparam logic [2:0] S_UP_RD  = 3'd3;
  localparam logic [2:0] S_UP_CMP = 3'd4;
  localparam logic [2:0] S_DN_RD  = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Sequence the sift walk
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          priority if (stat.go_ins) begin
            state_nxt = S_UP_RD;
          end else if (stat.go_del) begin
            state_nxt = S_LAST;
          end else if (stat.go_chg) begin
            state_nxt = S_CHG;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_LAST: begin
        cmd.take_last = 1'b1;
        state_nxt     = S_DN_RD;
      end
      S_CHG: begin
        priority if (stat.chg_lt) begin
          state_nxt = S_DN_RD;
        end else if (stat.chg_gt) begin
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          cmd.place = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.read_parent = 1'b1;
          state_nxt       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_move) begin
          cmd.move_up = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_DN_RD: begin
        if (stat.is_leaf) begin
          cmd.place = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.read_kids = 1'b1;
          state_nxt     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_move) begin
          cmd.move_down = 1'b1;
          state_nxt     = S_DN_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> $past(out_valid))
    else $error("block went idle without a result transfer");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

### rtl/core/max_heap_priority_queue_top.sv
// Binary max-heap priority queue of signed 32-bit keys.
//
// Request channel: present in_req_type, in_key_value and in_heap_index with
// start; the transfer happens at the clock edge where start is high and busy
// is low. Kinds: insert a key, delete the maximum, change the key at a heap
// position. Other kind codes change nothing and report status ok.
//
// Result channel: exactly one result per request, shown for a single cycle
// with out_valid high. It carries the removed maximum, the maximum after the
// request, the entry count and a status code. The receiver cannot stall; the
// result is taken in that cycle.
//
// Timing: keys live in a CAPACITY-deep RAM with registered reads, so each
// level of a sift takes a read state, then a compare-and-write state.
// busy drops the cycle after out_valid, and a new request is taken only
// once busy is low. With 64 entries the worst case is a key change
// walking six levels.
//
// Reset (rst_n low, synchronous) empties the heap at once; no clearing pass.
module max_heap_priority_queue_top #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mhpq_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [mhpq_pkg::KEY_W-1:0]    in_key_value,
  input  logic [mhpq_pkg::IDX_W-1:0]           in_heap_index,
  output logic                                 out_valid,
  output logic signed [mhpq_pkg::KEY_W-1:0]    out_removed_value,
  output logic signed [mhpq_pkg::KEY_W-1:0]    out_top_value,
  output logic [mhpq_pkg::TOTAL_W-1:0]         out_entry_total,
  output logic [mhpq_pkg::STATUS_W-1:0]        out_status
);
  import mhpq_pkg::*;

  mhpq_cmd_t  cmd;
  mhpq_stat_t stat;

  // Sequencer
  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Key store and sift datapath
  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_key_value      (in_key_value),
    .in_heap_index     (in_heap_index),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_entry_total   (out_entry_total),
    .out_status        (out_status)
  );

endmodule
